// ===== hw/rtl/csvft_pkg.sv =====
package csvft_pkg;

  localparam int unsigned MaxRes    = 5;
  localparam int unsigned CntW      = $clog2(MaxRes + 1);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic [15:0] ChQuote      = 16'h0022;
  localparam logic [15:0] ChComma      = 16'h002C;
  localparam logic [15:0] ChNewline    = 16'h000A;
  localparam logic [15:0] ChBackslash  = 16'h005C;
  localparam logic [15:0] ChLowerX     = 16'h0078;
  localparam logic [15:0] ChRightQuote = 16'h201D;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_AFTERQ = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_SLASH = 2'd1,
    ESC_X     = 2'd2,
    ESC_DIGIT = 2'd3
  } esc_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        has;
    logic        fe;
    logic        re;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]         cnt;
    res_t [MaxRes-1:0]       res;
  } bundle_t;

  function automatic logic is_hex(input logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) ||
           (u >= 16'h0061 && u <= 16'h0066) ||
           (u >= 16'h0041 && u <= 16'h0046);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [15:0] u);
    logic [15:0] d;
    d = 16'h0000;
    if (u >= 16'h0030 && u <= 16'h0039) d = u - 16'h0030;
    else if (u >= 16'h0061 && u <= 16'h0066) d = u - 16'h0057;
    else if (u >= 16'h0041 && u <= 16'h0046) d = u - 16'h0037;
    return d[3:0];
  endfunction

endpackage

// ===== hw/rtl/csv_field_tokenizer.sv =====
// CSV field tokenizer over UTF-16 code units. One code unit is accepted per clock while full is
// low; each produces zero to five results (content units, field-end and row-end marks), which
// leave one per clock in order while pop is high, the first of them from the queue entry that
// is written on acceptance. The output side therefore sets the sustained rate: an item's results
// leave one at a time, and a four-bundle queue between the classifier and the result sequencer
// absorbs bursts, so full rises only when bundles arrive faster than the output side drains
// them, as with items of several results in a row or while pop is held low.
module csv_field_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_unit,
  output logic        has_unit,
  output logic        field_end,
  output logic        row_end,
  output logic        run_last
);

  csvft_pkg::bundle_t front_bundle, head;
  logic               front_valid;
  logic               accept;
  logic               q_empty;
  logic               q_pop;

  assign accept = push && !full;

  csvft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .code_unit    (code_unit),
    .last_unit    (last_unit),
    .bundle       (front_bundle),
    .bundle_valid (front_valid)
  );

  csvft_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && front_valid),
    .wr_data (front_bundle),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_empty (q_empty)
  );

  csvft_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_unit  (out_unit),
    .has_unit  (has_unit),
    .field_end (field_end),
    .row_end   (row_end),
    .run_last  (run_last)
  );

endmodule

// ===== hw/rtl/csvft_front.sv =====
module csvft_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [15:0]         code_unit,
  input  logic                last_unit,
  output csvft_pkg::bundle_t  bundle,
  output logic                bundle_valid
);

  csvft_pkg::mode_t parse_mode, parse_mode_next;
  csvft_pkg::esc_t  escape_stage, escape_stage_next;
  logic [15:0]      held_digit_unit, held_digit_unit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode      <= csvft_pkg::MODE_START;
      escape_stage    <= csvft_pkg::ESC_NONE;
      held_digit_unit <= 16'h0000;
    end else if (accept) begin
      parse_mode      <= parse_mode_next;
      escape_stage    <= escape_stage_next;
      held_digit_unit <= held_digit_unit_next;
    end
  end

  always_comb begin
    csvft_pkg::res_t             slots [csvft_pkg::MaxRes];
    logic [csvft_pkg::CntW-1:0]  n;
    logic                        do_normal;
    logic                        row_done;
    logic                        hex_u;
    csvft_pkg::mode_t            m;

    for (int i = 0; i < csvft_pkg::MaxRes; i++) slots[i] = '0;
    n                    = '0;
    do_normal            = 1'b0;
    row_done             = 1'b0;
    hex_u                = csvft_pkg::is_hex(code_unit);
    m                    = parse_mode;
    parse_mode_next      = parse_mode;
    escape_stage_next    = escape_stage;
    held_digit_unit_next = held_digit_unit;

    // pending escape: either continue it or spill it literally
    unique case (escape_stage)
      csvft_pkg::ESC_SLASH: begin
        if (code_unit == csvft_pkg::ChLowerX) escape_stage_next = csvft_pkg::ESC_X;
        else do_normal = 1'b1;
      end
      csvft_pkg::ESC_X: begin
        if (hex_u) begin
          held_digit_unit_next = code_unit;
          escape_stage_next    = csvft_pkg::ESC_DIGIT;
        end else do_normal = 1'b1;
      end
      csvft_pkg::ESC_DIGIT: begin
        if (hex_u) begin
          slots[n] = '{unit: {8'h00, csvft_pkg::hex_nibble(held_digit_unit),
                              csvft_pkg::hex_nibble(code_unit)},
                       has: 1'b1, fe: 1'b0, re: 1'b0};
          n = n + 1'b1;
          escape_stage_next = csvft_pkg::ESC_NONE;
        end else do_normal = 1'b1;
      end
      default: do_normal = 1'b1;
    endcase

    if (do_normal) begin
      // broken escape goes out as it was typed
      if (escape_stage != csvft_pkg::ESC_NONE) begin
        slots[n] = '{unit: csvft_pkg::ChBackslash, has: 1'b1, fe: 1'b0, re: 1'b0};
        n = n + 1'b1;
      end
      if (escape_stage == csvft_pkg::ESC_X || escape_stage == csvft_pkg::ESC_DIGIT) begin
        slots[n] = '{unit: csvft_pkg::ChLowerX, has: 1'b1, fe: 1'b0, re: 1'b0};
        n = n + 1'b1;
      end
      if (escape_stage == csvft_pkg::ESC_DIGIT) begin
        slots[n] = '{unit: held_digit_unit, has: 1'b1, fe: 1'b0, re: 1'b0};
        n = n + 1'b1;
      end
      escape_stage_next = csvft_pkg::ESC_NONE;

      if (m == csvft_pkg::MODE_START) begin
        if (code_unit == csvft_pkg::ChQuote) parse_mode_next = csvft_pkg::MODE_QUOTED;
        m = csvft_pkg::MODE_PLAIN;
      end

      if (!(parse_mode == csvft_pkg::MODE_START && code_unit == csvft_pkg::ChQuote)) begin
        unique case (m) inside
          csvft_pkg::MODE_PLAIN, csvft_pkg::MODE_QUOTED: begin
            if (m == csvft_pkg::MODE_PLAIN && (code_unit == csvft_pkg::ChComma ||
                                               code_unit == csvft_pkg::ChNewline)) begin
              slots[n] = '{unit: 16'h0000, has: 1'b0, fe: 1'b1,
                           re: code_unit == csvft_pkg::ChNewline};
              n = n + 1'b1;
              row_done        = code_unit == csvft_pkg::ChNewline;
              parse_mode_next = csvft_pkg::MODE_START;
            end else if (m == csvft_pkg::MODE_QUOTED && code_unit == csvft_pkg::ChQuote) begin
              parse_mode_next = csvft_pkg::MODE_AFTERQ;
            end else begin
              parse_mode_next = m;
              if (code_unit == csvft_pkg::ChBackslash) begin
                escape_stage_next = csvft_pkg::ESC_SLASH;
              end else begin
                slots[n] = '{unit: (code_unit == csvft_pkg::ChRightQuote) ?
                                   csvft_pkg::ChQuote : code_unit,
                             has: 1'b1, fe: 1'b0, re: 1'b0};
                n = n + 1'b1;
              end
            end
          end
          default: begin
            // unit after the closing quote is the delimiter, unless it doubles the quote
            if (code_unit == csvft_pkg::ChQuote) begin
              slots[n] = '{unit: csvft_pkg::ChQuote, has: 1'b1, fe: 1'b0, re: 1'b0};
              n = n + 1'b1;
              parse_mode_next = csvft_pkg::MODE_QUOTED;
            end else begin
              slots[n] = '{unit: 16'h0000, has: 1'b0, fe: 1'b1,
                           re: code_unit == csvft_pkg::ChNewline};
              n = n + 1'b1;
              row_done        = code_unit == csvft_pkg::ChNewline;
              parse_mode_next = csvft_pkg::MODE_START;
            end
          end
        endcase
      end
    end

    if (last_unit) begin
      if (!row_done) begin
        if (escape_stage_next != csvft_pkg::ESC_NONE) begin
          slots[n] = '{unit: csvft_pkg::ChBackslash, has: 1'b1, fe: 1'b0, re: 1'b0};
          n = n + 1'b1;
        end
        if (escape_stage_next == csvft_pkg::ESC_X ||
            escape_stage_next == csvft_pkg::ESC_DIGIT) begin
          slots[n] = '{unit: csvft_pkg::ChLowerX, has: 1'b1, fe: 1'b0, re: 1'b0};
          n = n + 1'b1;
        end
        if (escape_stage_next == csvft_pkg::ESC_DIGIT) begin
          slots[n] = '{unit: held_digit_unit_next, has: 1'b1, fe: 1'b0, re: 1'b0};
          n = n + 1'b1;
        end
        slots[n] = '{unit: 16'h0000, has: 1'b0, fe: 1'b1, re: 1'b1};
        n = n + 1'b1;
      end
      parse_mode_next      = csvft_pkg::MODE_START;
      escape_stage_next    = csvft_pkg::ESC_NONE;
      held_digit_unit_next = 16'h0000;
    end

    for (int i = 0; i < csvft_pkg::MaxRes; i++) bundle.res[i] = slots[i];
    bundle.cnt   = n;
    bundle_valid = n != '0;
  end

endmodule

// ===== hw/rtl/csvft_queue.sv =====
module csvft_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  csvft_pkg::bundle_t  wr_data,
  output logic                full,
  input  logic                rd_en,
  output csvft_pkg::bundle_t  rd_data,
  output logic                q_empty
);

  csvft_pkg::bundle_t               entries [csvft_pkg::QueueDepth];
  logic [csvft_pkg::PtrW-1:0]       wr_ptr, rd_ptr;
  logic [csvft_pkg::QCntW-1:0]      count;
  logic                             do_wr, do_rd;

  assign full    = count == csvft_pkg::QCntW'(csvft_pkg::QueueDepth);
  assign q_empty = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/csvft_emit.sv =====
module csvft_emit (
  input  logic                clk,
  input  logic                rst,
  input  csvft_pkg::bundle_t  head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [15:0]         out_unit,
  output logic                has_unit,
  output logic                field_end,
  output logic                row_end,
  output logic                run_last
);

  logic [csvft_pkg::CntW-1:0] idx;
  csvft_pkg::res_t            cur;
  logic                       at_last;

  assign cur     = head.res[idx];
  assign at_last = idx == head.cnt - 1'b1;

  assign empty     = q_empty;
  assign out_unit  = cur.unit;
  assign has_unit  = cur.has;
  assign field_end = cur.fe;
  assign row_end   = cur.re;
  assign run_last  = at_last;
  // release the bundle once its final result is taken
  assign q_pop     = pop && !q_empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && !q_empty) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

endmodule
